FILE: hw/rtl/arc_replacement_policy_assert.svh
// Assertion macros shared by the directory RTL.
// Both sample on clk and are quiet while rst_n is low.
`ifndef ARC_REPLACEMENT_POLICY_ASSERT_SVH
`define ARC_REPLACEMENT_POLICY_ASSERT_SVH

// same-cycle implication
`define ARC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ARC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/arc_pkg.sv
package arc_pkg;

  // fixed field widths
  localparam int KEY_W     = 32;
  localparam int STAMP_W   = 32;
  localparam int LIST_W    = 3;
  localparam int CAP_W     = 7;
  localparam int OUT_CNT_W = 7;
  localparam int WORD_W    = LIST_W + STAMP_W + KEY_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // list codes, also reported as found_in
  localparam logic [LIST_W-1:0] L_NONE = 3'd0;
  localparam logic [LIST_W-1:0] L_T1   = 3'd1;
  localparam logic [LIST_W-1:0] L_T2   = 3'd2;
  localparam logic [LIST_W-1:0] L_B1   = 3'd3;
  localparam logic [LIST_W-1:0] L_B2   = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DIV,
    S_DROP,
    S_REP,
    S_FREE,
    S_GHOST,
    S_INST,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/arc_replacement_policy.sv
// ARC replacement directory.
// Input channel (in_valid/in_stall/in_key): one page key per word. The block
// takes one key at a time; in_stall is high from acceptance until the result
// word has been loaded into the output register.
// Output channel (out_valid/out_stall/out_*): one result word per key. A word
// waits in the output register while out_stall is high; the next key may be
// accepted and processed meanwhile, and its result waits in the last step
// until the register frees up.
// Config (cfg_valid/cfg_ready/cfg_capacity): capacity, ready is always high.
// Per key, acceptance to out_valid: a scan of all 2*MAX_ENTRIES directory
// entries through the directory RAM's single read port, then the hit,
// full-miss or ghost-hit steps; a ghost hit also waits for the divider. A
// miss that finds no free slot adds a second scan and a ghost drop. The
// next key is taken in the cycle after the result is loaded.
// After reset a clearing pass writes every one of the 2*MAX_ENTRIES entries,
// one per cycle, before the first key is accepted.
`include "arc_replacement_policy_assert.svh"
module arc_replacement_policy import arc_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_W-1:0]     in_key,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic                 out_fetch_request,
  output logic [2:0]           out_found_in,
  output logic                 out_evicted_valid,
  output logic [KEY_W-1:0]     out_evicted_key,
  output logic [OUT_CNT_W-1:0] out_target_p,
  output logic [OUT_CNT_W-1:0] out_t1_count,
  output logic [OUT_CNT_W-1:0] out_t2_count,
  output logic [OUT_CNT_W-1:0] out_b1_count,
  output logic [OUT_CNT_W-1:0] out_b2_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAP_W-1:0]     cfg_capacity
);

  localparam int DIR   = 2 * MAX_ENTRIES;
  localparam int AW    = $clog2(DIR);
  localparam int SCW   = AW + 1;
  localparam int CNT_W = $clog2(DIR + 1);
  localparam int CW    = (CNT_W + 2 > 9) ? CNT_W + 2 : 9;

  // list code to count slot: T1 0, T2 1, B1 2, B2 3
  function automatic logic [1:0] list_slot(logic [LIST_W-1:0] l);
    return 2'(l - 3'd1);
  endfunction

  state_t state_r, state_nxt;

  logic [SCW-1:0]     sc_r, sc_nxt;
  logic               pv_r, pv_nxt;
  logic [AW-1:0]      pa_r, pa_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [STAMP_W-1:0] rclk_r, rclk_nxt;
  logic [CAP_W-1:0]   p_r, p_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [CNT_W-1:0]   cnt_r [4];
  logic [CNT_W-1:0]   cnt_nxt [4];

  // scan results
  logic               fk_v_r, fk_v_nxt;
  logic [AW-1:0]      fk_idx_r, fk_idx_nxt;
  logic [LIST_W-1:0]  fk_list_r, fk_list_nxt;
  logic               ff_v_r, ff_v_nxt;
  logic [AW-1:0]      ff_idx_r, ff_idx_nxt;
  logic               lv_r [4];
  logic               lv_nxt [4];
  logic [AW-1:0]      li_r [4];
  logic [AW-1:0]      li_nxt [4];
  logic [STAMP_W-1:0] lage_r [4];
  logic [STAMP_W-1:0] lage_nxt [4];
  logic [KEY_W-1:0]   lkey_r [4];
  logic [KEY_W-1:0]   lkey_nxt [4];

  // per-request work state
  logic               ev_r, ev_nxt;
  logic [KEY_W-1:0]   evk_r, evk_nxt;
  logic               path_b_r, path_b_nxt;
  logic               in_b2_r, in_b2_nxt;
  logic               scan2_r, scan2_nxt;
  logic               drop_v_r, drop_v_nxt;
  logic [AW-1:0]      drop_idx_r, drop_idx_nxt;
  logic [1:0]         drop_j_r, drop_j_nxt;
  logic               do_rep_r, do_rep_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [LIST_W-1:0]  inst_list_r, inst_list_nxt;
  logic               dec_v_r, dec_v_nxt;
  logic [1:0]         dec_j_r, dec_j_nxt;
  logic [LIST_W-1:0]  found_r, found_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic                 o_hit_r;
  logic [2:0]           o_found_r;
  logic                 o_ev_r;
  logic [KEY_W-1:0]     o_evk_r;
  logic [OUT_CNT_W-1:0] o_p_r, o_t1_r, o_t2_r, o_b1_r, o_b2_r;

  // RAM and divider hookup
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              div_start;
  logic [CNT_W-1:0]  div_num, div_den;
  logic              div_done;
  logic [CNT_W-1:0]  div_quo;

  // decode and helpers
  logic [LIST_W-1:0]  rl;
  logic [STAMP_W-1:0] rs;
  logic [KEY_W-1:0]   rk;
  logic [STAMP_W-1:0] age;
  logic [1:0]         rj;
  logic [LIST_W-1:0]  found;
  logic [CW-1:0]      ce, l1, all_cnt, t1c, pe, dq, np;
  logic               sel_t1;
  logic [1:0]         vj;

  arc_ram #(.WIDTH(WORD_W), .DEPTH(DIR)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  arc_div #(.W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // word fields and effective capacity
  assign rl  = ram_rdata[WORD_W-1 -: LIST_W];
  assign rs  = ram_rdata[KEY_W +: STAMP_W];
  assign rk  = ram_rdata[KEY_W-1:0];
  assign age = rclk_r - rs;
  assign rj  = list_slot(rl);
  assign ce  = (cap_r == '0) ? CW'(1) :
               ((CW'(cap_r) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cap_r));
  assign found   = fk_v_r ? fk_list_r : L_NONE;
  assign l1      = CW'(cnt_r[0]) + CW'(cnt_r[2]);
  assign all_cnt = l1 + CW'(cnt_r[1]) + CW'(cnt_r[3]);
  assign t1c     = CW'(cnt_r[0]);
  assign pe      = CW'(p_r);
  assign div_num = (found == L_B1) ? cnt_r[3] : cnt_r[2];
  assign div_den = (found == L_B1) ? cnt_r[2] : cnt_r[3];
  // ghost delta: max(1, ratio), zero divisor gives 1
  assign dq = (div_den == '0 || div_quo == '0) ? CW'(1) : CW'(div_quo);
  assign np = pe + dq;
  // replace: T1 side when above target, or at target on a B2 hit
  assign sel_t1 = (t1c != '0) && ((t1c > pe) || (in_b2_r && (t1c == pe)));

  always_comb begin
    state_nxt     = state_r;
    sc_nxt        = sc_r;
    pv_nxt        = 1'b0;
    pa_nxt        = pa_r;
    key_nxt       = key_r;
    rclk_nxt      = rclk_r;
    p_nxt         = p_r;
    cap_nxt       = cfg_valid ? cfg_capacity : cap_r;
    cnt_nxt       = cnt_r;
    fk_v_nxt      = fk_v_r;
    fk_idx_nxt    = fk_idx_r;
    fk_list_nxt   = fk_list_r;
    ff_v_nxt      = ff_v_r;
    ff_idx_nxt    = ff_idx_r;
    lv_nxt        = lv_r;
    li_nxt        = li_r;
    lage_nxt      = lage_r;
    lkey_nxt      = lkey_r;
    ev_nxt        = ev_r;
    evk_nxt       = evk_r;
    path_b_nxt    = path_b_r;
    in_b2_nxt     = in_b2_r;
    scan2_nxt     = scan2_r;
    drop_v_nxt    = drop_v_r;
    drop_idx_nxt  = drop_idx_r;
    drop_j_nxt    = drop_j_r;
    do_rep_nxt    = do_rep_r;
    slot_nxt      = slot_r;
    inst_list_nxt = inst_list_r;
    dec_v_nxt     = dec_v_r;
    dec_j_nxt     = dec_j_r;
    found_nxt     = found_r;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = {inst_list_r, rclk_r, key_r};
    ram_raddr     = sc_r[AW-1:0];
    div_start     = 1'b0;
    vj            = sel_t1 ? 2'd0 : 2'd1;

    // fold in the word read last cycle
    if (pv_r) begin
      if (rl != L_NONE && rk == key_r && !fk_v_r) begin
        fk_v_nxt    = 1'b1;
        fk_idx_nxt  = pa_r;
        fk_list_nxt = rl;
      end
      if (rl == L_NONE && !ff_v_r) begin
        ff_v_nxt   = 1'b1;
        ff_idx_nxt = pa_r;
      end
      if (rl inside {[L_T1:L_B2]}) begin
        if (!lv_r[rj] || age > lage_r[rj]) begin
          lv_nxt[rj]   = 1'b1;
          li_nxt[rj]   = pa_r;
          lage_nxt[rj] = age;
          lkey_nxt[rj] = rk;
        end
      end
    end

    case (state_r)
      // write every entry empty
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sc_r[AW-1:0];
        ram_wdata = {L_NONE, {(STAMP_W + KEY_W){1'b0}}};
        if (sc_r == SCW'(DIR - 1)) begin
          sc_nxt    = '0;
          state_nxt = S_IDLE;
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt    = in_key;
          ev_nxt     = 1'b0;
          evk_nxt    = '0;
          path_b_nxt = 1'b0;
          in_b2_nxt  = 1'b0;
          scan2_nxt  = 1'b0;
          drop_v_nxt = 1'b0;
          sc_nxt     = '0;
          fk_v_nxt   = 1'b0;
          ff_v_nxt   = 1'b0;
          lv_nxt     = '{default: 1'b0};
          state_nxt  = S_SCAN;
        end
      end
      // issue one read per cycle, the last word lands in the next cycle
      S_SCAN: begin
        if (sc_r != SCW'(DIR)) begin
          pv_nxt = 1'b1;
          pa_nxt = sc_r[AW-1:0];
          sc_nxt = sc_r + 1'b1;
        end else if (!pv_r) begin
          state_nxt = scan2_r ? S_GHOST : S_DECIDE;
        end
      end
      S_DECIDE: begin
        found_nxt = found;
        case (found)
          L_T1, L_T2: begin
            slot_nxt      = fk_idx_r;
            inst_list_nxt = L_T2;
            dec_v_nxt     = 1'b1;
            dec_j_nxt     = list_slot(found);
            state_nxt     = S_INST;
          end
          L_B1, L_B2: begin
            slot_nxt      = fk_idx_r;
            inst_list_nxt = L_T2;
            dec_v_nxt     = 1'b1;
            dec_j_nxt     = list_slot(found);
            path_b_nxt    = 1'b1;
            in_b2_nxt     = (found == L_B2);
            div_start     = 1'b1;
            state_nxt     = S_DIV;
          end
          default: begin
            // full miss: L1 and total-size rules
            inst_list_nxt = L_T1;
            dec_v_nxt     = 1'b0;
            drop_v_nxt    = 1'b0;
            do_rep_nxt    = 1'b0;
            drop_idx_nxt  = li_r[2];
            drop_j_nxt    = 2'd2;
            if (l1 == ce) begin
              if (t1c < ce) begin
                drop_v_nxt = lv_r[2];
                do_rep_nxt = 1'b1;
              end else begin
                drop_v_nxt   = lv_r[0];
                drop_idx_nxt = li_r[0];
                drop_j_nxt   = 2'd0;
                if (lv_r[0]) begin
                  ev_nxt  = 1'b1;
                  evk_nxt = lkey_r[0];
                end
              end
            end else if (all_cnt >= ce) begin
              if (all_cnt == (ce << 1)) begin
                drop_v_nxt   = lv_r[3];
                drop_idx_nxt = li_r[3];
                drop_j_nxt   = 2'd3;
              end
              do_rep_nxt = 1'b1;
            end
            state_nxt = S_DROP;
          end
        endcase
      end
      // adapt the target once the ratio is known
      S_DIV: begin
        if (div_done) begin
          if (in_b2_r) begin
            p_nxt = CAP_W'((dq < pe) ? (pe - dq) : CW'(0));
          end else begin
            p_nxt = CAP_W'((np > ce) ? ce : np);
          end
          state_nxt = S_REP;
        end
      end
      S_DROP: begin
        if (drop_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = drop_idx_r;
          ram_wdata = {L_NONE, rclk_r, key_r};
          cnt_nxt[drop_j_r] = cnt_r[drop_j_r] - 1'b1;
        end
        state_nxt = do_rep_r ? S_REP : S_FREE;
      end
      // move the LRU resident page to its ghost list
      S_REP: begin
        if (!lv_r[vj]) begin
          vj = vj ^ 2'd1;
        end
        if (lv_r[vj]) begin
          ram_we    = 1'b1;
          ram_waddr = li_r[vj];
          ram_wdata = {3'(vj) + 3'd3, rclk_r, lkey_r[vj]};
          cnt_nxt[vj]         = cnt_r[vj] - 1'b1;
          cnt_nxt[vj + 2'd2]  = cnt_r[vj + 2'd2] + 1'b1;
          rclk_nxt  = rclk_r + 1'b1;
          ev_nxt    = 1'b1;
          evk_nxt   = lkey_r[vj];
        end
        state_nxt = path_b_r ? S_INST : S_FREE;
      end
      // lowest free slot: first free of the scan or the slot just dropped
      S_FREE: begin
        if (ff_v_r || drop_v_r) begin
          slot_nxt  = (ff_v_r && (!drop_v_r || ff_idx_r < drop_idx_r)) ?
                      ff_idx_r : drop_idx_r;
          state_nxt = S_INST;
        end else begin
          scan2_nxt = 1'b1;
          sc_nxt    = '0;
          fk_v_nxt  = 1'b0;
          ff_v_nxt  = 1'b0;
          lv_nxt    = '{default: 1'b0};
          state_nxt = S_SCAN;
        end
      end
      // directory full: drop LRU of B2, else of B1
      S_GHOST: begin
        if (lv_r[3] || lv_r[2]) begin
          ram_we    = 1'b1;
          ram_waddr = lv_r[3] ? li_r[3] : li_r[2];
          ram_wdata = {L_NONE, rclk_r, key_r};
          slot_nxt  = lv_r[3] ? li_r[3] : li_r[2];
          if (lv_r[3]) begin
            cnt_nxt[3] = cnt_r[3] - 1'b1;
          end else begin
            cnt_nxt[2] = cnt_r[2] - 1'b1;
          end
          state_nxt = S_INST;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INST: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = {inst_list_r, rclk_r, key_r};
        if (dec_v_r) begin
          cnt_nxt[dec_j_r] = cnt_nxt[dec_j_r] - 1'b1;
        end
        cnt_nxt[list_slot(inst_list_r)] = cnt_nxt[list_slot(inst_list_r)] + 1'b1;
        rclk_nxt  = rclk_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // output word register
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sc_r        <= '0;
      pv_r        <= 1'b0;
      rclk_r      <= '0;
      p_r         <= '0;
      cap_r       <= CAP_RESET;
      cnt_r       <= '{default: '0};
      fk_v_r      <= 1'b0;
      ff_v_r      <= 1'b0;
      lv_r        <= '{default: 1'b0};
      ev_r        <= 1'b0;
      path_b_r    <= 1'b0;
      in_b2_r     <= 1'b0;
      scan2_r     <= 1'b0;
      drop_v_r    <= 1'b0;
      do_rep_r    <= 1'b0;
      dec_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      pv_r        <= pv_nxt;
      rclk_r      <= rclk_nxt;
      p_r         <= p_nxt;
      cap_r       <= cap_nxt;
      cnt_r       <= cnt_nxt;
      fk_v_r      <= fk_v_nxt;
      ff_v_r      <= ff_v_nxt;
      lv_r        <= lv_nxt;
      ev_r        <= ev_nxt;
      path_b_r    <= path_b_nxt;
      in_b2_r     <= in_b2_nxt;
      scan2_r     <= scan2_nxt;
      drop_v_r    <= drop_v_nxt;
      do_rep_r    <= do_rep_nxt;
      dec_v_r     <= dec_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pa_r        <= pa_nxt;
    key_r       <= key_nxt;
    fk_idx_r    <= fk_idx_nxt;
    fk_list_r   <= fk_list_nxt;
    ff_idx_r    <= ff_idx_nxt;
    li_r        <= li_nxt;
    lage_r      <= lage_nxt;
    lkey_r      <= lkey_nxt;
    evk_r       <= evk_nxt;
    drop_idx_r  <= drop_idx_nxt;
    drop_j_r    <= drop_j_nxt;
    slot_r      <= slot_nxt;
    inst_list_r <= inst_list_nxt;
    dec_j_r     <= dec_j_nxt;
    found_r     <= found_nxt;
    if (out_load) begin
      o_hit_r   <= (found_r == L_T1) || (found_r == L_T2);
      o_found_r <= found_r;
      o_ev_r    <= ev_r;
      o_evk_r   <= ev_r ? evk_r : '0;
      o_p_r     <= p_r;
      o_t1_r    <= OUT_CNT_W'(cnt_r[0]);
      o_t2_r    <= OUT_CNT_W'(cnt_r[1]);
      o_b1_r    <= OUT_CNT_W'(cnt_r[2]);
      o_b2_r    <= OUT_CNT_W'(cnt_r[3]);
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_hit           = o_hit_r;
  assign out_fetch_request = ~o_hit_r;
  assign out_found_in      = o_found_r;
  assign out_evicted_valid = o_ev_r;
  assign out_evicted_key   = o_evk_r;
  assign out_target_p      = o_p_r;
  assign out_t1_count      = o_t1_r;
  assign out_t2_count      = o_t2_r;
  assign out_b1_count      = o_b1_r;
  assign out_b2_count      = o_b2_r;

  // checks
  `ARC_ASSERT(a_no_write_in_scan, state_r == S_SCAN, !ram_we, "RAM written during scan")
  `ARC_ASSERT(a_div_done_in_div, div_done, state_r == S_DIV, "divider finished outside wait")
  `ARC_ASSERT_NEXT(a_accept_scans, in_valid && !in_stall, state_r == S_SCAN, "accept not scanned")
  `ARC_ASSERT(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "stray result word")
  `ARC_ASSERT(a_count_bound, state_r != S_CLEAR,
    (CW'(cnt_r[0]) + CW'(cnt_r[1]) + CW'(cnt_r[2]) + CW'(cnt_r[3])) <= CW'(DIR),
    "list counts exceed directory")

endmodule

FILE: hw/rtl/arc_ram.sv
// Single write port, single read port, registered read.
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/arc_div.sv
// Restoring divider, one quotient bit per cycle.
// done pulses in the cycle after the last step; quo holds until the next start.
module arc_div #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int SW = (W > 1) ? $clog2(W) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // one shift-subtract step
  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    diff     = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = diff[W] ? shifted[W-1:0] : diff[W-1:0];
      quo_nxt = {quo_r[W-2:0], ~diff[W]};
      if (step_r == SW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
